[rtl/c2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the 2D convolution accumulator.
// ----------------------------------------------------------------------------
package c2d_pkg;

  // Default values of the top-level parameters.
  localparam int KERNEL_SIZE_DEF = 5;
  localparam int MAX_WIDTH_DEF   = 64;
  localparam int DATA_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int SUM_W       = 40;
  localparam int OUT_COORD_W = 6;
  localparam int COORD_MAX_W = 8;
  localparam int CFG_W       = 7;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd32;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh80_0000_0000;

  // Window token handed from the front end to the datapath.
  typedef struct packed {
    logic                   vld;
    logic                   first;
    logic [COORD_MAX_W-1:0] row;
    logic [COORD_MAX_W-1:0] col;
    logic                   last;
  } tok_t;

  // One finished result waiting in the output queue.
  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [OUT_COORD_W-1:0] row;
    logic [OUT_COORD_W-1:0] col;
    logic                   last;
  } result_t;

endpackage

[rtl/conv2d_valid_multichannel_accumulate.sv]
`timescale 1ns / 1ps
// Result path: a completing pixel passes the window and token registers, the
// product registers, the saturating sum chain, the dot register and the queue.
// Throughput: one item per cycle; input stalls only when the result queue's
// credits (a power of two at least KERNEL_SIZE^2 + 6) are all in use.
// Reset: asynchronous active low; position returns to the origin, width to 32.
// Kernel, line buffers and partial sums hold no reset and need no clearing pass.
// ----------------------------------------------------------------------------
// conv2d_valid_multichannel_accumulate
// Valid stride-1 2D convolution with per-position accumulation over channels.
// ----------------------------------------------------------------------------
module conv2d_valid_multichannel_accumulate #(
  parameter int KERNEL_SIZE = c2d_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = c2d_pkg::MAX_WIDTH_DEF,
  parameter int DATA_BITS   = c2d_pkg::DATA_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [c2d_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic [2:0]                           weight_row_i,
  input  logic [2:0]                           weight_col_i,
  input  logic signed [DATA_BITS-1:0]          value_i,
  input  logic                                 first_channel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [c2d_pkg::SUM_W-1:0]     out_sum_o,
  output logic [c2d_pkg::OUT_COORD_W-1:0]      out_row_o,
  output logic [c2d_pkg::OUT_COORD_W-1:0]      out_col_o,
  output logic                                 last_of_pass_o
);
  import c2d_pkg::*;

  localparam int TAPS   = KERNEL_SIZE * KERNEL_SIZE;
  localparam int QDEPTH = 2 ** $clog2(TAPS + 6);

  tok_t                tok;
  logic [TAPS*DATA_BITS-1:0] window, kernel;
  logic                push, pop;
  result_t             result, head;

  assign pop = out_valid_o & ~out_stall_i;

  // Front end.
  c2d_front #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .DATA_BITS   (DATA_BITS),
    .QDEPTH      (QDEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .weight_row_i    (weight_row_i),
    .weight_col_i    (weight_col_i),
    .value_i         (value_i),
    .first_channel_i (first_channel_i),
    .pop_i           (pop),
    .tok_o           (tok),
    .window_o        (window),
    .kernel_o        (kernel)
  );

  // Datapath.
  c2d_back #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .DATA_BITS   (DATA_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tok_i    (tok),
    .window_i (window),
    .kernel_i (kernel),
    .push_o   (push),
    .result_o (result)
  );

  // Output queue.
  c2d_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (result),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign out_sum_o      = head.sum;
  assign out_row_o      = head.row;
  assign out_col_o      = head.col;
  assign last_of_pass_o = head.last;

endmodule

[rtl/c2d_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/c2d_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_front
// Input front end: kernel loads, raster position, line buffers, window
// registers and credit-based flow control toward the output queue.
// ----------------------------------------------------------------------------
module c2d_front #(
  parameter int KERNEL_SIZE = 5,
  parameter int MAX_WIDTH   = 64,
  parameter int DATA_BITS   = 16,
  parameter int QDEPTH      = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [c2d_pkg::CFG_W-1:0]                  cfg_wdata_i,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic                                       action_i,
  input  logic [2:0]                                 weight_row_i,
  input  logic [2:0]                                 weight_col_i,
  input  logic signed [DATA_BITS-1:0]                value_i,
  input  logic                                       first_channel_i,
  input  logic                                       pop_i,
  output c2d_pkg::tok_t                              tok_o,
  output logic [KERNEL_SIZE*KERNEL_SIZE*DATA_BITS-1:0] window_o,
  output logic [KERNEL_SIZE*KERNEL_SIZE*DATA_BITS-1:0] kernel_o
);
  import c2d_pkg::*;

  localparam int TAPS  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINES = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam int D     = DATA_BITS;

  // Clamp a written width to the supported range.
  function automatic logic [WW-1:0] clamp_width(logic [CFG_W-1:0] raw);
    logic [9:0] w;
    w = 10'(raw);
    if (w < 10'(KERNEL_SIZE)) w = 10'(KERNEL_SIZE);
    if (w > 10'(MAX_WIDTH))   w = 10'(MAX_WIDTH);
    return WW'(w);
  endfunction

  logic [WW-1:0]        width_q;
  logic [CW-1:0]        row_q, row_d, col_q, col_d;
  logic [CW-1:0]        cur_row, cur_col;
  logic [WW-1:0]        col_inc, row_inc;
  logic                 pix_acc, wgt_acc, complete, issue;
  logic [CNT_W-1:0]     cnt_q;
  logic [LINES*D-1:0]   line_rdata, line_wdata;
  logic [5:0]           wgt_idx;
  tok_t                 tok_q;
  logic [TAPS*D-1:0]    window_q, kernel_q;

  assign in_stall_o = (cnt_q == CNT_W'(QDEPTH));
  assign pix_acc    = in_valid_i & ~in_stall_o & action_i;
  assign wgt_acc    = in_valid_i & ~in_stall_o & ~action_i;

  // Current position, folded to the origin if it lies outside the image.
  always_comb begin
    cur_row = row_q;
    cur_col = col_q;
    if (WW'(row_q) >= width_q || WW'(col_q) >= width_q) begin
      cur_row = '0;
      cur_col = '0;
    end
    col_inc = WW'(cur_col) + WW'(1);
    row_inc = WW'(cur_row) + WW'(1);
  end

  assign complete = (WW'(cur_row) >= WW'(KERNEL_SIZE - 1)) &&
                    (WW'(cur_col) >= WW'(KERNEL_SIZE - 1));
  assign issue = pix_acc & complete;

  // Next raster position.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (pix_acc) begin
      row_d = cur_row;
      col_d = CW'(col_inc);
      if (col_inc >= width_q) begin
        col_d = '0;
        row_d = (row_inc >= width_q) ? '0 : CW'(row_inc);
      end
    end
  end

  // Width register and position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= clamp_width(WIDTH_RESET);
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      if (cfg_we_i) width_q <= clamp_width(cfg_wdata_i);
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Outstanding results, in flight or queued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(issue) - CNT_W'(pop_i);
    end
  end

  // Line buffers: one word per column holds the older rows of that column.
  // The read address runs one pixel ahead so data waits at the port.
  always_comb begin
    line_wdata = line_rdata;
    for (int k = 0; k < LINES; k++) begin
      if (k + 1 < KERNEL_SIZE - 1) begin
        line_wdata[k*D +: D] = line_rdata[(k+1)*D +: D];
      end else begin
        line_wdata[k*D +: D] = value_i;
      end
    end
  end

  c2d_ram #(
    .WIDTH (LINES * D),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (pix_acc && (KERNEL_SIZE > 1)),
    .waddr_i (cur_col),
    .wdata_i (line_wdata),
    .raddr_i (col_d),
    .rdata_o (line_rdata)
  );

  // Sliding window: each row shifts left and takes its new tap on the right.
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        for (int j = 0; j + 1 < KERNEL_SIZE; j++) begin
          window_q[(k*KERNEL_SIZE+j)*D +: D] <= window_q[(k*KERNEL_SIZE+j+1)*D +: D];
        end
        if (k < KERNEL_SIZE - 1) begin
          window_q[(k*KERNEL_SIZE+KERNEL_SIZE-1)*D +: D] <= line_rdata[k*D +: D];
        end else begin
          window_q[(k*KERNEL_SIZE+KERNEL_SIZE-1)*D +: D] <= value_i;
        end
      end
    end
  end

  // Kernel taps; loads outside the kernel are dropped.
  assign wgt_idx = 6'(weight_row_i) * 6'(KERNEL_SIZE) + 6'(weight_col_i);

  always_ff @(posedge clk_i) begin
    if (wgt_acc && (32'(weight_row_i) < KERNEL_SIZE) &&
        (32'(weight_col_i) < KERNEL_SIZE)) begin
      for (int t = 0; t < TAPS; t++) begin
        if (wgt_idx == 6'(t)) kernel_q[t*D +: D] <= value_i;
      end
    end
  end

  // Window token for the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.vld   <= issue;
      tok_q.first <= first_channel_i;
      tok_q.row   <= COORD_MAX_W'(cur_row - CW'(KERNEL_SIZE - 1));
      tok_q.col   <= COORD_MAX_W'(cur_col - CW'(KERNEL_SIZE - 1));
      tok_q.last  <= (row_inc == width_q) && (col_inc == width_q);
    end
  end

  assign tok_o    = tok_q;
  assign window_o = window_q;
  assign kernel_o = kernel_q;

endmodule

[rtl/c2d_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_back
// Datapath: parallel tap products, an ordered saturating sum chain and the
// read-modify-write of the partial sum store.
// ----------------------------------------------------------------------------
module c2d_back #(
  parameter int KERNEL_SIZE = 5,
  parameter int MAX_WIDTH   = 64,
  parameter int DATA_BITS   = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  c2d_pkg::tok_t                                tok_i,
  input  logic [KERNEL_SIZE*KERNEL_SIZE*DATA_BITS-1:0] window_i,
  input  logic [KERNEL_SIZE*KERNEL_SIZE*DATA_BITS-1:0] kernel_i,
  output logic                                         push_o,
  output c2d_pkg::result_t                             result_o
);
  import c2d_pkg::*;

  localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;
  localparam int D    = DATA_BITS;
  localparam int PW   = 2 * D;
  localparam int SW   = ((PW > SUM_W) ? PW : SUM_W) + 1;
  localparam int CW   = $clog2(MAX_WIDTH);

  localparam logic signed [SW-1:0] SMAX = SW'(SUM_MAX);
  localparam logic signed [SW-1:0] SMIN = SW'(SUM_MIN);

  // Add and clip to the 40-bit signed range.
  function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                      logic signed [PW-1:0] b);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s > SMAX) return SUM_MAX;
    if (s < SMIN) return SUM_MIN;
    return SUM_W'(s);
  endfunction

  tok_t                    tok_q   [TAPS+1];
  logic signed [PW-1:0]    prod_q  [TAPS][TAPS];
  logic signed [SUM_W-1:0] acc_q   [TAPS];
  tok_t                    tok_r_q;
  logic signed [SUM_W-1:0] dot_r_q;
  logic [SUM_W-1:0]        ps_rdata;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W:0]   acc_sum;

  // Token pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= TAPS; s++) tok_q[s] <= '0;
      tok_r_q <= '0;
    end else begin
      tok_q[0] <= tok_i;
      for (int s = 0; s < TAPS; s++) tok_q[s+1] <= tok_q[s];
      tok_r_q <= tok_q[TAPS];
    end
  end

  // Products of all taps, then one saturating add per stage in window order.
  always_ff @(posedge clk_i) begin
    for (int t = 0; t < TAPS; t++) begin
      prod_q[0][t] <= $signed(window_i[t*D +: D]) * $signed(kernel_i[t*D +: D]);
    end
    for (int s = 0; s + 1 < TAPS; s++) begin
      prod_q[s+1] <= prod_q[s];
    end
    for (int s = 0; s < TAPS; s++) begin
      acc_q[s] <= sat_add((s == 0) ? '0 : acc_q[(s == 0) ? 0 : s-1], prod_q[s][s]);
    end
    dot_r_q <= acc_q[TAPS-1];
  end

  // Partial sums: read as the dot product leaves the chain, written in the cycle after.
  c2d_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH * MAX_WIDTH)
  ) u_psum_ram (
    .clk_i   (clk_i),
    .we_i    (tok_r_q.vld),
    .waddr_i ({tok_r_q.row[CW-1:0], tok_r_q.col[CW-1:0]}),
    .wdata_i (sum),
    .raddr_i ({tok_q[TAPS].row[CW-1:0], tok_q[TAPS].col[CW-1:0]}),
    .rdata_o (ps_rdata)
  );

  // Restart or accumulate.
  always_comb begin
    acc_sum = $signed({ps_rdata[SUM_W-1], ps_rdata}) +
              $signed({dot_r_q[SUM_W-1], dot_r_q});
    if (tok_r_q.first) begin
      sum = dot_r_q;
    end else if (acc_sum > (SUM_W+1)'(SUM_MAX)) begin
      sum = SUM_MAX;
    end else if (acc_sum < (SUM_W+1)'(SUM_MIN)) begin
      sum = SUM_MIN;
    end else begin
      sum = SUM_W'(acc_sum);
    end
  end

  assign push_o        = tok_r_q.vld;
  assign result_o.sum  = sum;
  assign result_o.row  = tok_r_q.row[OUT_COORD_W-1:0];
  assign result_o.col  = tok_r_q.col[OUT_COORD_W-1:0];
  assign result_o.last = tok_r_q.last;

endmodule

[rtl/c2d_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_queue
// Result queue between the datapath and the output channel.
// ----------------------------------------------------------------------------
module c2d_queue #(
  parameter int DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  c2d_pkg::result_t entry_i,
  input  logic             pop_i,
  output logic             valid_o,
  output c2d_pkg::result_t head_o
);
  import c2d_pkg::*;

  localparam int AW = $clog2(DEPTH);

  result_t       mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  // Pointers and fill level; the credit count upstream keeps it from overflowing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(1);
      if (pop_i)  rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= entry_i;
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];

endmodule

[rtl/c2d_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_checker
// Port-level checks of the convolution accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module c2d_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [c2d_pkg::SUM_W-1:0]         out_sum_o,
  input logic [c2d_pkg::OUT_COORD_W-1:0]   out_row_o,
  input logic [c2d_pkg::OUT_COORD_W-1:0]   out_col_o,
  input logic                              last_of_pass_o
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_sum_o) && $stable(out_row_o) &&
                                   $stable(out_col_o) && $stable(last_of_pass_o))
    else $error("stalled result changed");

  // The image is square, so its final position lies on the diagonal.
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_pass_o |-> out_row_o == out_col_o)
    else $error("last position off the diagonal");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered after reset");

endmodule

bind conv2d_valid_multichannel_accumulate c2d_checker u_c2d_checker (.*);
